[hdl/mpq_pkg.sv]
// Shared types and constants for the min priority queue array unit.
package mpq_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W  = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [1:0]               status;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
    } t_out_word;

    typedef struct packed {
        logic                     en;
        logic [ADDR_W-1:0]        addr;
        logic signed [DATA_W-1:0] data;
    } t_wr_req;

endpackage

[hdl/mpq_store.sv]
// Entry memory: one write port, one read port with registered read data.
module mpq_store (
    input  logic                             i_clk,
    input  mpq_pkg::t_wr_req                 i_wr,
    input  logic [mpq_pkg::ADDR_W-1:0]       i_rd_addr,
    output logic signed [mpq_pkg::DATA_W-1:0] o_rd_data
);
    import mpq_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/mpq_seq.sv]
// Sequencer: insert, minimum scan and shift-down passes over the entry memory.
module mpq_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  mpq_pkg::t_in_word                 i_item,
    output logic                              o_busy,
    output logic                              o_valid,
    output mpq_pkg::t_out_word                o_result,
    output mpq_pkg::t_wr_req                  o_wr,
    output logic [mpq_pkg::ADDR_W-1:0]        o_rd_addr,
    input  logic signed [mpq_pkg::DATA_W-1:0] i_rd_data
);
    import mpq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_SHIFT = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic                     r_pv, n_pv;
    logic [ADDR_W-1:0]        r_pidx, n_pidx;
    logic signed [DATA_W-1:0] r_best_val, n_best_val;
    logic [ADDR_W-1:0]        r_best_idx, n_best_idx;
    logic                     r_valid, n_valid;
    t_out_word                r_result, n_result;

    logic                     accept;
    logic                     issue;
    logic [CNT_W-1:0]         count_dec;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign issue     = (r_ptr < r_count);
    assign count_dec = r_count - CNT_W'(1);
    assign o_rd_addr = r_ptr[ADDR_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_valid    = 1'b0;
        n_result   = r_result;
        o_wr.en    = 1'b0;
        o_wr.addr  = r_count[ADDR_W-1:0];
        o_wr.data  = i_item.value;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_valid                = 1'b1;
                    n_result.removed_value = '0;
                    n_result.status        = STATUS_OK;
                    n_result.is_empty      = (r_count == '0);
                    n_result.occupancy     = OCC_W'(r_count);
                    if (i_item.operation == OP_INSERT) begin
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_result.status = STATUS_FULL;
                        end else begin
                            o_wr.en            = 1'b1;
                            n_count            = r_count + CNT_W'(1);
                            n_result.is_empty  = 1'b0;
                            n_result.occupancy = OCC_W'(r_count + CNT_W'(1));
                        end
                    end else if (r_count == '0) begin
                        n_result.status = STATUS_EMPTY;
                    end else begin
                        // hold the result until the scan and shift complete
                        n_valid = 1'b0;
                        n_ptr   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ptr[ADDR_W-1:0];
                    n_ptr  = r_ptr + CNT_W'(1);
                end
                // strict compare keeps the oldest of equal values
                if (r_pv && ((r_pidx == '0) || (i_rd_data < r_best_val))) begin
                    n_best_val = i_rd_data;
                    n_best_idx = r_pidx;
                end
                if (!issue && !r_pv) begin
                    n_ptr   = CNT_W'(r_best_idx) + CNT_W'(1);
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (issue) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ptr[ADDR_W-1:0];
                    n_ptr  = r_ptr + CNT_W'(1);
                end
                if (r_pv) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_pidx - ADDR_W'(1);
                    o_wr.data = i_rd_data;
                end
                if (!issue && !r_pv) begin
                    n_count                = count_dec;
                    n_valid                = 1'b1;
                    n_result.removed_value = r_best_val;
                    n_result.status        = STATUS_OK;
                    n_result.is_empty      = (count_dec == '0);
                    n_result.occupancy     = OCC_W'(count_dec);
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_pidx     <= n_pidx;
        r_best_val <= n_best_val;
        r_best_idx <= n_best_idx;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hdl/min_priority_queue_array_unit.sv]
// Top level of the min priority queue over an unsorted entry memory.
//
//  channel   ports                         direction  handshake
//  command   i_start, o_busy, i_item       in         taken when i_start && !o_busy
//  result    o_valid, o_result             out        one-cycle strobe, never held off
//
// An insert or a remove on an empty queue gives its result the cycle after it
// is taken, and the unit is ready again at once.
// A remove with n entries stored, the smallest at index b, keeps o_busy high while
// it scans all n entries for the minimum, then while it shifts the entries from
// b + 1 to the end down one place; nothing is shifted when the smallest is last.
// Its result is strobed in the first cycle with o_busy low.
// Reset clears the entry count and the sequencer; memory contents are not cleared.
// Results are strobed for one cycle and cannot be stalled.
module min_priority_queue_array_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  mpq_pkg::t_in_word   i_item,
    output logic                o_busy,
    output logic                o_valid,
    output mpq_pkg::t_out_word  o_result
);
    import mpq_pkg::*;

    t_wr_req                  wr;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    mpq_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mpq_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_item    (i_item),
        .o_busy    (o_busy),
        .o_valid   (o_valid),
        .o_result  (o_result),
        .o_wr      (wr),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    a_insert_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_item.operation == OP_INSERT)) |=> o_valid)
        else $error("insert produced no result in the next cycle");

    a_busy_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_busy && o_valid))
        else $error("result strobed while a remove is still in progress");

    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STATUS_FULL)) |->
        ((o_result.occupancy == OCC_W'(DEPTH)) && !o_result.is_empty))
        else $error("full status reported with queue not full");

    a_empty_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == STATUS_EMPTY)) |->
        (o_result.is_empty && (o_result.removed_value == '0)))
        else $error("empty status reported with entries present or a value");

endmodule
